// ===== hw/rtl/slt_pkg.sv =====
// Shared types and codes for the sorted list table.
// No dependencies; imported by slt_cell and sorted_list_table.
`timescale 1ns / 1ps

package slt_pkg;

    localparam int OP_W = 3;
    localparam int ST_W = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_REWIND = 3'd4;
    localparam logic [OP_W-1:0] OP_READ   = 3'd5;

    localparam logic [ST_W-1:0] ST_OK          = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL_REJ    = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY_REJ   = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_PRESENT = 3'd3;
    localparam logic [ST_W-1:0] ST_PAST_END    = 3'd4;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/sorted_list_table.sv =====
// Sorted list table: ascending store of signed items built as a chain of compare cells.
// Depends on slt_pkg and slt_cell.
//
//  port group     dir  contents (lowest bit first)
//  i_s_*          in   tuser: operation; tdata: value
//  o_m_*          out  tdata: found, status, item_out, count, is_full, is_empty
//
// Operations act on the whole chain: all cells compare against the value at once
// and shift their entries to a neighbour in the same cycle; the result lands in an
// output register. A new word is taken whenever that register is empty or being read.
// Reset (synchronous, active low) empties the store and rewinds the cursor.
// Entries above the count hold stale data and are never reported.
`timescale 1ns / 1ps

module sorted_list_table
    import slt_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int IN_DW     = ((ITEM_WIDTH + 7) / 8) * 8,
    localparam int OUT_RW    = 1 + ST_W + ITEM_WIDTH + CNT_W + 2,
    localparam int OUT_DW    = ((OUT_RW + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_DW-1:0]     i_s_tdata,   // value
    input  logic [OP_W-1:0]      i_s_tuser,   // operation
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_DW-1:0]    o_m_tdata    // found, status, item_out, count, full, empty
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_cursor, n_cursor;
    logic                  r_out_valid;
    logic                  r_found, n_found;
    logic [ST_W-1:0]       r_status, n_status;
    logic [ITEM_WIDTH-1:0] r_item, n_item;

    logic                  w_accept;
    logic [OP_W-1:0]       w_op;
    logic [ITEM_WIDTH-1:0] w_value;
    logic                  w_full, w_empty, w_any_hit, w_read_ok;
    t_cell_ctl             w_ctl;

    logic [ITEM_WIDTH-1:0] w_data [CAPACITY];
    logic                  w_lt   [CAPACITY];
    logic [CAPACITY-1:0]   w_hit;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_op       = i_s_tuser;
    assign w_value    = i_s_tdata[ITEM_WIDTH-1:0];
    assign w_full     = (r_count == CAP_C);
    assign w_empty    = (r_count == '0);
    assign w_any_hit  = |w_hit;
    assign w_read_ok  = (r_cursor < r_count) && (r_cursor < CAP_C);

    assign w_ctl.ins = w_accept && (w_op == OP_INSERT) && !w_full;
    assign w_ctl.del = w_accept && (w_op == OP_DELETE) && w_any_hit;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        slt_cell #(
            .IDX        (g),
            .ITEM_WIDTH (ITEM_WIDTH),
            .CNT_W      (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_value      (w_value),
            .i_count      (r_count),
            .i_left_lt    ((g == 0) ? 1'b1 : w_lt[(g == 0) ? 0 : g - 1]),
            .i_left_data  ((g == 0) ? w_value : w_data[(g == 0) ? 0 : g - 1]),
            .i_right_data ((g == CAPACITY - 1) ? w_data[g]
                                               : w_data[(g == CAPACITY - 1) ? g : g + 1]),
            .o_data       (w_data[g]),
            .o_lt         (w_lt[g]),
            .o_hit        (w_hit[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        n_found  = 1'b0;
        n_status = ST_OK;
        n_item   = '0;
        case (w_op)
            OP_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL_REJ;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_DELETE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY_REJ;
                end else if (w_any_hit) begin
                    n_count = r_count - 1'b1;
                    n_found = 1'b1;
                end else begin
                    n_status = ST_NOT_PRESENT;
                end
            end
            OP_SEARCH: n_found  = w_any_hit;
            OP_CLEAR:  n_count  = '0;
            OP_REWIND: n_cursor = '0;
            OP_READ: begin
                if (w_read_ok) begin
                    n_item   = w_data[r_cursor[IDX_W-1:0]];
                    n_cursor = r_cursor + 1'b1;
                end else begin
                    n_status = ST_PAST_END;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_cursor    <= n_cursor;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the result word; count flags are taken from the stored count
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found  <= n_found;
            r_status <= n_status;
            r_item   <= n_item;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DW'({w_empty, w_full, r_count, r_item, r_status, r_found});

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("stored count above capacity");

    a_insert_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the store");

    a_delete_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.del |-> !w_empty && $onehot(w_hit))
        else $error("delete without a single lower-bound match");

    a_clear_empties : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_CLEAR)) |=> w_empty)
        else $error("clear left entries behind");

endmodule

// ===== hw/rtl/slt_cell.sv =====
// One cell of the sorted chain: holds a single entry and compares it against the word.
// Depends on slt_pkg for the command struct.
`timescale 1ns / 1ps

module slt_cell
    import slt_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int ITEM_WIDTH = 32,
    parameter int CNT_W      = 7
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [ITEM_WIDTH-1:0] i_value,
    input  logic [CNT_W-1:0]      i_count,
    input  logic                  i_left_lt,
    input  logic [ITEM_WIDTH-1:0] i_left_data,
    input  logic [ITEM_WIDTH-1:0] i_right_data,
    output logic [ITEM_WIDTH-1:0] o_data,
    output logic                  o_lt,
    output logic                  o_hit
);

    logic [ITEM_WIDTH-1:0] r_data;
    logic [ITEM_WIDTH-1:0] n_data;
    logic                  w_occupied;

    assign w_occupied = CNT_W'(IDX) < i_count;
    assign o_lt       = w_occupied && ($signed(r_data) < $signed(i_value));
    // lower-bound cell (first occupied one not below the value) hits if equal to it
    assign o_hit      = w_occupied && !o_lt && i_left_lt && (r_data == i_value);
    assign o_data     = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins && !o_lt) begin
            n_data = i_left_lt ? i_value : i_left_data;
        end else if (i_ctl.del && !o_lt) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule
